FILE: rtl/srcs_pkg.sv
// ----------------------------------------------------------------------------
// srcs_pkg
// Shared constants, register indexes and the duty table for the step-response
// capture sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package srcs_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int TICK_BITS_DEF   = 12;

  localparam int DUTY_W     = 7;
  localparam int LEVEL_W    = 4;
  localparam int RUNS_W     = 4;
  localparam int CFG_ADDR_W = 3;

  // register reset values, truncated to the tick width where they are used
  localparam int DRIVE_OFF_RST = 600;
  localparam int CAPTURE_RST   = 1200;
  localparam int PERIOD_RST    = 3000;

  localparam logic [RUNS_W-1:0]  RUNS_RST  = RUNS_W'(12);
  localparam logic [LEVEL_W-1:0] TOP_RST   = LEVEL_W'(12);
  localparam logic [LEVEL_W-1:0] LEVEL_RST = LEVEL_W'(1);

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_DRIVE_OFF = 3'd0,
    CFG_CAPTURE   = 3'd1,
    CFG_PERIOD    = 3'd2,
    CFG_RUNS      = 3'd3,
    CFG_TOP       = 3'd4
  } cfg_idx_e;

  // PWM compare for a drive level: level * 100 / 12
  function automatic logic [DUTY_W-1:0] duty_of(input logic [LEVEL_W-1:0] lvl);
    logic [DUTY_W-1:0] d;
    begin
      case (lvl)
        4'd0:    d = 7'd0;
        4'd1:    d = 7'd8;
        4'd2:    d = 7'd16;
        4'd3:    d = 7'd25;
        4'd4:    d = 7'd33;
        4'd5:    d = 7'd41;
        4'd6:    d = 7'd50;
        4'd7:    d = 7'd58;
        4'd8:    d = 7'd66;
        4'd9:    d = 7'd75;
        4'd10:   d = 7'd83;
        4'd11:   d = 7'd91;
        4'd12:   d = 7'd100;
        4'd13:   d = 7'd108;
        4'd14:   d = 7'd116;
        4'd15:   d = 7'd125;
        default: d = 7'd0;
      endcase
      return d;
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/srcs_core.sv
// ----------------------------------------------------------------------------
// srcs_core
// Configuration registers, sequencer state and the per-tick step logic.
// ----------------------------------------------------------------------------
`default_nettype none

module srcs_core
  import srcs_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int TICK_BITS   = TICK_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  wire logic [TICK_BITS-1:0]   cfg_wdata_i,
  input  wire logic                   step_i,
  input  wire logic [SAMPLE_BITS-1:0] encoder_count_i,
  output logic      [DUTY_W-1:0]      drive_duty_o,
  output logic                        sample_valid_o,
  output logic      [SAMPLE_BITS-1:0] sample_value_o,
  output logic      [TICK_BITS-1:0]   sample_index_o,
  output logic                        last_sample_o,
  output logic                        encoder_clear_o,
  output logic      [LEVEL_W-1:0]     drive_level_o,
  output logic                        finished_o
);

  localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

  logic [TICK_BITS-1:0] drive_off_q, capture_q, period_q;
  logic [RUNS_W-1:0]    runs_per_level_q;
  logic [LEVEL_W-1:0]   top_level_q;

  logic                 running_q, running_d;
  logic [TICK_BITS-1:0] tick_q, tick_d;
  logic [RUNS_W-1:0]    runs_q, runs_d;
  logic [LEVEL_W-1:0]   level_q, level_d;
  logic [DUTY_W-1:0]    duty_q, duty_d;

  logic [TICK_BITS-1:0] tick_inc, tick_inc2;
  logic [LEVEL_W-1:0]   level_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_off_q      <= TICK_BITS'(DRIVE_OFF_RST);
      capture_q        <= TICK_BITS'(CAPTURE_RST);
      period_q         <= TICK_BITS'(PERIOD_RST);
      runs_per_level_q <= RUNS_RST;
      top_level_q      <= TOP_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_DRIVE_OFF: drive_off_q      <= cfg_wdata_i;
        CFG_CAPTURE:   capture_q        <= cfg_wdata_i;
        CFG_PERIOD:    period_q         <= cfg_wdata_i;
        CFG_RUNS:      runs_per_level_q <= cfg_wdata_i[RUNS_W-1:0];
        CFG_TOP:       top_level_q      <= cfg_wdata_i[LEVEL_W-1:0];
        default:       ;
      endcase
    end
  end

  // saturating index increments; the second one serves the end-of-run tick
  assign tick_inc  = (tick_q == TICK_MAX) ? tick_q : tick_q + 1'b1;
  assign tick_inc2 = (tick_inc == TICK_MAX) ? tick_inc : tick_inc + 1'b1;
  assign level_inc = level_q + 1'b1;

  always_comb begin
    running_d       = running_q;
    tick_d          = tick_q;
    runs_d          = runs_q;
    level_d         = level_q;
    duty_d          = duty_q;
    sample_valid_o  = 1'b0;
    sample_value_o  = '0;
    sample_index_o  = '0;
    last_sample_o   = 1'b0;
    encoder_clear_o = 1'b0;
    if (running_q) begin
      sample_valid_o = 1'b1;
      sample_value_o = encoder_count_i;
      sample_index_o = tick_q;
      tick_d         = tick_inc;
      // drive-off wins over end of run when both hit the same index
      if (tick_inc == drive_off_q) begin
        duty_d = '0;
      end else if (tick_inc == capture_q) begin
        last_sample_o = 1'b1;
        running_d     = 1'b0;
        tick_d        = tick_inc2;
        runs_d        = runs_q + 1'b1;
      end
    end else if (runs_q < runs_per_level_q) begin
      if (tick_q == period_q) begin
        duty_d          = duty_of(level_q);
        running_d       = 1'b1;
        tick_d          = '0;
        encoder_clear_o = 1'b1;
      end else begin
        tick_d = tick_inc;
      end
    end else if (level_q < top_level_q) begin
      if (tick_q == period_q) begin
        level_d         = level_inc;
        duty_d          = duty_of(level_inc);
        running_d       = 1'b1;
        runs_d          = '0;
        tick_d          = '0;
        encoder_clear_o = 1'b1;
      end else begin
        tick_d = tick_inc;
      end
    end
  end

  assign drive_duty_o  = duty_d;
  assign drive_level_o = level_d;
  assign finished_o    = !running_d && (runs_d >= runs_per_level_q) &&
                         (level_d >= top_level_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b1;
      tick_q    <= '0;
      runs_q    <= '0;
      level_q   <= LEVEL_RST;
      duty_q    <= duty_of(LEVEL_RST);
    end else if (step_i) begin
      running_q <= running_d;
      tick_q    <= tick_d;
      runs_q    <= runs_d;
      level_q   <= level_d;
      duty_q    <= duty_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/srcs_out_buf.sv
// ----------------------------------------------------------------------------
// srcs_out_buf
// Two-entry result buffer; keeps the input side open while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module srcs_out_buf #(
  parameter int DATA_W = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [DATA_W-1:0] data_i,
  output logic                   ready_o,
  output logic                   valid_o,
  input  wire logic              pop_ready_i,
  output logic      [DATA_W-1:0] data_o
);

  localparam logic [1:0] DEPTH = 2'd2;

  logic [1:0]        count_q, count_d;
  logic [DATA_W-1:0] head_q, tail_q;
  logic              push, pop;

  assign ready_o = (count_q != DEPTH);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = head_q;
  assign push    = push_i && ready_o;
  assign pop     = valid_o && pop_ready_i;

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      // advance the tail, or take the new item straight into the head
      if (count_q == DEPTH) begin
        head_q <= tail_q;
      end else if (push) begin
        head_q <= data_i;
      end
    end else if (push) begin
      if (count_q == 2'd0) begin
        head_q <= data_i;
      end else begin
        tail_q <= data_i;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/step_response_capture_sequencer_unit.sv
// ----------------------------------------------------------------------------
// step_response_capture_sequencer_unit
// Step-response capture sequencer: one tick item in, one result item out.
// ----------------------------------------------------------------------------
// Each accepted tick item produces exactly one result item, registered in the result buffer.
// A tick can be accepted every cycle: the step logic is a few index compares
// and a 16-entry duty table between the sequencer state registers and a
// two-entry result buffer, so ready stays high while up to one result waits
// on the output side. Configuration writes take effect on the next tick.
`default_nettype none

module step_response_capture_sequencer_unit
  import srcs_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int TICK_BITS   = TICK_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  wire logic [TICK_BITS-1:0]   cfg_wdata_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [SAMPLE_BITS-1:0] encoder_count_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic      [DUTY_W-1:0]      drive_duty_o,
  output logic                        sample_valid_o,
  output logic      [SAMPLE_BITS-1:0] sample_value_o,
  output logic      [TICK_BITS-1:0]   sample_index_o,
  output logic                        last_sample_o,
  output logic                        encoder_clear_o,
  output logic      [LEVEL_W-1:0]     drive_level_o,
  output logic                        finished_o
);

  localparam int RES_W = DUTY_W + SAMPLE_BITS + TICK_BITS + LEVEL_W + 4;

  logic                   step;
  logic [DUTY_W-1:0]      duty;
  logic                   s_valid, s_last, clr, fin;
  logic [SAMPLE_BITS-1:0] s_value;
  logic [TICK_BITS-1:0]   s_index;
  logic [LEVEL_W-1:0]     level;
  logic [RES_W-1:0]       res_in, res_out;

  assign step = in_valid_i && in_ready_o;

  srcs_core #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .TICK_BITS  (TICK_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .step_i         (step),
    .encoder_count_i(encoder_count_i),
    .drive_duty_o   (duty),
    .sample_valid_o (s_valid),
    .sample_value_o (s_value),
    .sample_index_o (s_index),
    .last_sample_o  (s_last),
    .encoder_clear_o(clr),
    .drive_level_o  (level),
    .finished_o     (fin)
  );

  assign res_in = {duty, s_valid, s_value, s_index, s_last, clr, level, fin};

  srcs_out_buf #(
    .DATA_W(RES_W)
  ) u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_valid_i),
    .data_i     (res_in),
    .ready_o    (in_ready_o),
    .valid_o    (out_valid_o),
    .pop_ready_i(out_ready_i),
    .data_o     (res_out)
  );

  assign {drive_duty_o, sample_valid_o, sample_value_o, sample_index_o,
          last_sample_o, encoder_clear_o, drive_level_o, finished_o} = res_out;

endmodule

`default_nettype wire

FILE: rtl/srcs_checker.sv
// ----------------------------------------------------------------------------
// srcs_checker
// Port-level checks for the step-response capture sequencer, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module srcs_checker
  import srcs_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int TICK_BITS   = TICK_BITS_DEF
) (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_ready_o,
  input wire logic                   out_valid_o,
  input wire logic                   out_ready_i,
  input wire logic [DUTY_W-1:0]      drive_duty_o,
  input wire logic                   sample_valid_o,
  input wire logic [SAMPLE_BITS-1:0] sample_value_o,
  input wire logic [TICK_BITS-1:0]   sample_index_o,
  input wire logic                   last_sample_o,
  input wire logic                   encoder_clear_o
);

  // a waiting result is held until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // no sample fields without a captured sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !sample_valid_o |->
      sample_value_o == '0 && sample_index_o == '0 && !last_sample_o)
    else $error("sample fields set on a tick without a sample");

  // a restart tick is an idle tick and turns the drive back on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && encoder_clear_o |-> !sample_valid_o && drive_duty_o != '0)
    else $error("bad restart item");

  // the buffer never refuses a tick while it is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with an empty result buffer");

endmodule

bind step_response_capture_sequencer_unit srcs_checker #(
  .SAMPLE_BITS(SAMPLE_BITS),
  .TICK_BITS  (TICK_BITS)
) u_srcs_checker (.*);

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the step-response capture sequencer. A cycle model
// of the sequencer predicts the result of every accepted tick and a scoreboard
// compares each result field by field. Directed ticks walk a short sequence
// to its end, and random phases reprogram the registers between bursts of
// random encoder counts, with random idling, a long output stall, and a
// stretch without gaps.
// ----------------------------------------------------------------------------
module tb_top;
  import srcs_pkg::*;

  typedef struct packed {
    logic [DUTY_W-1:0]  duty;
    logic               smp_valid;
    logic [15:0]        smp_value;
    logic [11:0]        smp_index;
    logic               smp_last;
    logic               enc_clear;
    logic [LEVEL_W-1:0] level;
    logic               done;
  } tick_result_t;

  class capture_scoreboard;
    logic [11:0]        drive_off;
    logic [11:0]        capture_len;
    logic [11:0]        period_len;
    logic [3:0]         runs_per_lvl;
    logic [3:0]         top_lvl;
    bit                 capturing;
    logic [11:0]        tick_idx;
    logic [3:0]         runs_done;
    logic [LEVEL_W-1:0] level;
    logic [DUTY_W-1:0]  duty;
    tick_result_t       expected_q[$];
    int                 errors;

    function new();
      drive_off    = 12'd600;
      capture_len  = 12'd1200;
      period_len   = 12'd3000;
      runs_per_lvl = 4'd12;
      top_lvl      = 4'd12;
      capturing    = 1'b1;
      tick_idx     = '0;
      runs_done    = '0;
      level        = 4'd1;
      duty         = level_duty(4'd1);
      errors       = 0;
    endfunction

    function logic [11:0] bump(logic [11:0] v);
      return (v == 12'hFFF) ? v : v + 12'd1;
    endfunction

    function logic [DUTY_W-1:0] level_duty(logic [LEVEL_W-1:0] lvl);
      int scaled;
      scaled = int'(lvl) * 100 / 12;
      return DUTY_W'(scaled);
    endfunction

    function void write_reg(cfg_idx_e idx, logic [11:0] data);
      case (idx)
        CFG_DRIVE_OFF: drive_off = data;
        CFG_CAPTURE:   capture_len = data;
        CFG_PERIOD:    period_len = data;
        CFG_RUNS:      runs_per_lvl = data[3:0];
        CFG_TOP:       top_lvl = data[3:0];
        default: ;
      endcase
    endfunction

    function void note_tick(logic [15:0] count);
      tick_result_t r;
      r = '0;
      if (capturing) begin
        r.smp_valid = 1'b1;
        r.smp_value = count;
        r.smp_index = tick_idx;
        tick_idx = bump(tick_idx);
        // drive-off takes priority over the end of the run
        if (tick_idx == drive_off) begin
          duty = '0;
        end else if (tick_idx == capture_len) begin
          r.smp_last = 1'b1;
          capturing = 1'b0;
          tick_idx = bump(tick_idx);
          runs_done++;
        end
      end else if (runs_done < runs_per_lvl || level < top_lvl) begin
        if (tick_idx == period_len) begin
          // runs at this level used up: step the level
          if (runs_done >= runs_per_lvl) begin
            level++;
            runs_done = '0;
          end
          duty = level_duty(level);
          capturing = 1'b1;
          tick_idx = '0;
          r.enc_clear = 1'b1;
        end else begin
          tick_idx = bump(tick_idx);
        end
      end
      r.duty  = duty;
      r.level = level;
      r.done  = !capturing && runs_done >= runs_per_lvl && level >= top_lvl;
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch: %s", msg);
    endtask

    task cmp_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task check_result(tick_result_t got);
      tick_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result %h with nothing outstanding", got));
        return;
      end
      want = expected_q.pop_front();
      cmp_field("drive_duty", got.duty, want.duty);
      cmp_field("sample_valid", got.smp_valid, want.smp_valid);
      cmp_field("sample_value", got.smp_value, want.smp_value);
      cmp_field("sample_index", got.smp_index, want.smp_index);
      cmp_field("last_sample", got.smp_last, want.smp_last);
      cmp_field("encoder_clear", got.enc_clear, want.enc_clear);
      cmp_field("drive_level", got.level, want.level);
      cmp_field("finished", got.done, want.done);
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = CFG_DRIVE_OFF;
  logic [11:0]           cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [15:0]           encoder_count_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [DUTY_W-1:0]     drive_duty_o;
  logic                  sample_valid_o;
  logic [15:0]           sample_value_o;
  logic [11:0]           sample_index_o;
  logic                  last_sample_o;
  logic                  encoder_clear_o;
  logic [LEVEL_W-1:0]    drive_level_o;
  logic                  finished_o;

  capture_scoreboard sb = new();
  tick_result_t      seen;
  bit                steady = 1'b0;
  bit                hold_req = 1'b0;
  int                hold_left = 0;

  step_response_capture_sequencer_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .encoder_count_i (encoder_count_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .drive_duty_o    (drive_duty_o),
    .sample_valid_o  (sample_valid_o),
    .sample_value_o  (sample_value_o),
    .sample_index_o  (sample_index_o),
    .last_sample_o   (last_sample_o),
    .encoder_clear_o (encoder_clear_o),
    .drive_level_o   (drive_level_o),
    .finished_o      (finished_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // result side: check accepted items, then pick next ready
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        seen = {drive_duty_o, sample_valid_o, sample_value_o, sample_index_o,
                last_sample_o, encoder_clear_o, drive_level_o, finished_o};
        sb.check_result(seen);
      end
      if (hold_req) begin
        hold_left = 80;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= steady || ($urandom_range(99) >= 13);
      end
    end
  end

  task send_tick(logic [15:0] count);
    while (!steady && $urandom_range(99) < 13) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    encoder_count_i <= count;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_tick(count);
  endtask

  // drop valid and hold until every outstanding result is back
  task settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.expected_q.size() != 0);
  endtask

  task write_cfg(cfg_idx_e idx, logic [11:0] data);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task load_regs(logic [11:0] doff, logic [11:0] cap, logic [11:0] per,
                 logic [3:0] runs, logic [3:0] top);
    write_cfg(CFG_DRIVE_OFF, doff);
    write_cfg(CFG_CAPTURE, cap);
    write_cfg(CFG_PERIOD, per);
    // upper data bits are don't-care for the 4-bit registers
    write_cfg(CFG_RUNS, {8'($urandom), runs});
    write_cfg(CFG_TOP, {8'($urandom), top});
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    #(12 * 200000);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int n;
    int phase;
    int random_items;
    int base;
    int t;
    logic [11:0] cap;
    logic [11:0] doff;
    logic [11:0] per;
    logic [3:0]  runs;
    logic [3:0]  top;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // short sequence: two levels of one run each, then finished
    load_regs(12'd2, 12'd4, 12'd6, 4'd1, 4'd2);
    send_tick(16'h0000);
    send_tick(16'hFFFF);
    send_tick(16'h5555);
    send_tick(16'hAAAA);
    repeat (10) send_tick(16'($urandom));

    random_items = 0;
    phase = 0;
    while (random_items < 1900) begin
      settle();
      cap = 12'($urandom_range(1, 10));
      if ($urandom_range(9) == 0) begin
        cap = '0;
      end else if (sb.capturing && sb.tick_idx >= cap && sb.tick_idx < 12'd4000) begin
        // index already past the end: move the end ahead of it
        cap = sb.tick_idx + 12'($urandom_range(1, 6));
      end
      case ($urandom_range(5))
        0:       doff = cap;
        1:       doff = 12'hFFF;
        default: doff = 12'($urandom_range(0, int'(cap) + 3));
      endcase
      base = int'(cap);
      if (!sb.capturing && int'(sb.tick_idx) > base) base = int'(sb.tick_idx);
      if ($urandom_range(7) == 0) per = 12'($urandom_range(0, int'(cap)));
      else per = 12'(base + $urandom_range(1, 8));
      case ($urandom_range(11))
        0:       runs = 4'd0;
        1:       runs = 4'd15;
        default: runs = 4'($urandom_range(1, 4));
      endcase
      if ($urandom_range(7) == 0) begin
        top = 4'($urandom_range(0, int'(sb.level)));
      end else begin
        t = int'(sb.level) + $urandom_range(0, 2);
        top = (t > 15) ? 4'd15 : 4'(t);
      end
      load_regs(doff, cap, per, runs, top);

      steady = (phase == 4);
      if (phase == 2) hold_req = 1'b1;
      n = steady ? 300 : $urandom_range(40, 140);
      repeat (n) send_tick(16'($urandom));
      random_items += n;
      phase++;
    end
    steady = 1'b0;

    settle();
    repeat (6) @(posedge clk_i);
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
